// ===== hdl/ipv4sbf_pkg.sv =====
// Shared types and constants for the IPv4 source blocklist filter.
// Holds status codes, header bounds and the structs passed between modules.
// No dependencies.
package ipv4sbf_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 256;

  localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;
  localparam logic [15:0] IP_END_BYTES     = 16'd34;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

  localparam logic FUNC_CLASSIFY = 1'b0;
  localparam logic FUNC_UPDATE   = 1'b1;

  localparam logic [2:0] ST_SHORT    = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd1;
  localparam logic [2:0] ST_LEARNED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ALLOWED  = 3'd4;
  localparam logic [2:0] ST_BLOCKED  = 3'd5;
  localparam logic [2:0] ST_UPDATED  = 3'd6;
  localparam logic [2:0] ST_REFUSED  = 3'd7;

  // One stored table entry.
  typedef struct packed {
    logic [31:0] key;
    logic        allow;
  } entry_t;

  // A decoded command handed from the front end to the sequencer.
  typedef struct packed {
    logic        func;
    logic        lookup;
    logic [31:0] key;
    logic        allow_val;
    logic [2:0]  status;
  } cmd_t;

endpackage

// ===== hdl/ipv4sbf_key_store.sv =====
// Key table memory: one write port and one read port with registered read data.
// Depends on ipv4sbf_pkg for the entry type.
module ipv4sbf_key_store
  import ipv4sbf_pkg::*;
#(
  parameter int DEPTH = DEFAULT_TABLE_ENTRIES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ipv4sbf_seq.sv =====
// Search sequencer: walks the filled part of the key table with one shared
// comparator, then learns, updates or reports, and registers the result.
// Depends on ipv4sbf_pkg and drives ipv4sbf_key_store.
module ipv4sbf_seq
  import ipv4sbf_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
  parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cmd_t          cmd,
  output logic          busy,
  output logic          done,
  output logic          drop,
  output logic [2:0]    status,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic          state;
  logic          state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic          func_r;
  logic [31:0]   key_r;
  logic          allow_r;

  logic match;
  logic finish;
  logic room;
  logic accept;

  assign busy   = (state == ST_SEARCH);
  assign accept = start && (state == ST_IDLE);

  // The comparator sees the entry read in the previous cycle.
  assign match  = cmp_valid && (rd_data.key == key_r);
  assign room   = (count < CW'(TABLE_ENTRIES));
  assign rd_en  = (state == ST_SEARCH) && (idx < count) && !match;
  assign rd_addr = idx[AW-1:0];
  assign finish = (state == ST_SEARCH) && (match || (idx >= count));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = '{key: key_r, allow: (func_r == FUNC_UPDATE) ? allow_r : 1'b1};
    if (finish) begin
      if (match) begin
        wr_en   = (func_r == FUNC_UPDATE);
        wr_addr = cmp_idx;
        wr_data = '{key: key_r, allow: allow_r};
      end else begin
        wr_en = room;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd.lookup) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= rd_en;
      done      <= 1'b0;
      if (accept) begin
        idx       <= '0;
        cmp_valid <= 1'b0;
        done      <= !cmd.lookup;
      end else if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (finish) begin
        done <= 1'b1;
        if (!match && room) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx <= idx[AW-1:0];
    end
    if (accept) begin
      func_r  <= cmd.func;
      key_r   <= cmd.key;
      allow_r <= cmd.allow_val;
      drop    <= 1'b0;
      status  <= cmd.status;
    end else if (finish) begin
      drop <= 1'b0;
      if (match) begin
        if (func_r == FUNC_UPDATE) begin
          status <= ST_UPDATED;
        end else if (rd_data.allow) begin
          status <= ST_ALLOWED;
        end else begin
          drop   <= 1'b1;
          status <= ST_BLOCKED;
        end
      end else if (room) begin
        status <= (func_r == FUNC_UPDATE) ? ST_UPDATED : ST_LEARNED;
      end else begin
        status <= (func_r == FUNC_UPDATE) ? ST_REFUSED : ST_FULL;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + 1'b1))
    else $error("entry count moved by more than one");

  a_no_done_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> !done)
    else $error("result strobe during a search");

  a_cmp_in_search: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == ST_SEARCH))
    else $error("compare pending outside a search");

endmodule

// ===== hdl/ipv4_source_block_filter_unit.sv =====
// Top level of the IPv4 source blocklist filter.
// Header checks in front, search sequencer and key table memory behind.
// Depends on ipv4sbf_pkg, ipv4sbf_key_store and ipv4sbf_seq.
//
// Usage: a command transaction is taken at a rising edge where start is high
// and busy is low. func 0 classifies a frame by its length, EtherType and
// source address; func 1 sets the allow bit of source_address to allow_bit.
// Each transaction gives exactly one result on drop and status, shown for
// one cycle with done high; the receiver cannot stall, so it must take it.
// Frames that are short or not IPv4 finish without a search: done rises in
// the cycle after the transaction and busy stays low. All other transactions
// search the filled entries (at most TABLE_ENTRIES) one per cycle through a
// single read port and comparator; busy is high meanwhile. A hit ends
// the search early. Learning or updating writes the table in the final cycle.
// Reset empties the table at once by clearing the fill count; no sweep.
module ipv4_source_block_filter_unit
  import ipv4sbf_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] frame_length,
  input  logic [15:0] ether_type,
  input  logic [31:0] source_address,
  input  logic        allow_bit,
  output logic        done,
  output logic        drop,
  output logic [2:0]  status
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  cmd_t          cmd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  // Updates always search; for classify, header bounds and EtherType decide whether a table search is needed.
  always_comb begin
    cmd.func      = func;
    cmd.key       = source_address;
    cmd.allow_val = allow_bit;
    cmd.lookup    = 1'b0;
    cmd.status    = ST_SHORT;
    if (func == FUNC_UPDATE) begin
      cmd.lookup = 1'b1;
    end else if (frame_length < ETH_HEADER_BYTES) begin
      cmd.status = ST_SHORT;
    end else if (ether_type != ETHERTYPE_IPV4) begin
      cmd.status = ST_NOT_IPV4;
    end else if (frame_length < IP_END_BYTES) begin
      cmd.status = ST_SHORT;
    end else begin
      cmd.lookup = 1'b1;
    end
  end

  ipv4sbf_seq #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .drop(drop),
    .status(status),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ipv4sbf_key_store #(
    .DEPTH(TABLE_ENTRIES),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
